>>> hw/rtl/itp_pkg.sv
package itp_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 32;
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Command kinds.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NONE   = 3'd0;
  localparam kind_t KIND_ALNUM  = 3'd1;
  localparam kind_t KIND_LPAREN = 3'd2;
  localparam kind_t KIND_RPAREN = 3'd3;
  localparam kind_t KIND_OP     = 3'd4;
  localparam kind_t KIND_END    = 3'd5;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic cmd_t classify(input logic [7:0] c, input logic fin);
    cmd_t r;
    r.ch   = c;
    r.kind = KIND_NONE;
    if (fin) begin
      r.kind = KIND_END;
    end else if (is_alnum(c)) begin
      r.kind = KIND_ALNUM;
    end else if (c == CH_LPAREN) begin
      r.kind = KIND_LPAREN;
    end else if (c == CH_RPAREN) begin
      r.kind = KIND_RPAREN;
    end else if (prec_of(c) != 2'd0) begin
      r.kind = KIND_OP;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/itp_intf.sv
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_expr;

  modport source(output valid, output char_in, output end_of_expr, input ready);
  modport sink(input valid, input char_in, input end_of_expr, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       expr_done;
  logic       run_last;

  modport source(output valid, output char_out, output expr_done, output run_last,
                 input ready);
  modport sink(input valid, input char_out, input expr_done, input run_last,
               output ready);
endinterface

>>> hw/rtl/itp_front.sv
module itp_front (
  itp_in_if.sink        in_chan,
  input  logic          q_ready,
  output logic          q_valid,
  output itp_pkg::cmd_t q_cmd
);
  import itp_pkg::*;

  // Characters that do nothing are accepted and dropped here.
  assign q_cmd         = classify(in_chan.char_in, in_chan.end_of_expr);
  assign in_chan.ready = q_ready;
  assign q_valid       = in_chan.valid && (q_cmd.kind != KIND_NONE);
endmodule

>>> hw/rtl/itp_queue.sv
module itp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  itp_pkg::cmd_t wr_cmd,
  output logic          wr_ready,
  output logic          rd_valid,
  output itp_pkg::cmd_t rd_cmd,
  input  logic          rd_pop
);
  import itp_pkg::*;

  cmd_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = fill != Q_CNT_W'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

>>> hw/rtl/itp_back.sv
module itp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  itp_pkg::cmd_t q_cmd,
  output logic          q_pop,
  itp_out_if.source     out_chan
);
  import itp_pkg::*;

  // The top of stack is kept in its own register; the array is read only
  // at the entry below it, so one pop can tell whether another will follow.
  logic [7:0]           op_stack [STACK_DEPTH];
  logic [STK_CNT_W-1:0] count;
  logic [7:0]           top;
  logic [STK_CNT_W-1:0] cnt_m2;
  logic [7:0]           below;
  logic                 has;
  logic                 more;
  logic [1:0]           p_in;
  logic                 out_free;
  logic                 step;
  logic                 emit;
  logic [7:0]           e_char;
  logic                 e_done;
  logic                 e_last;
  logic                 do_pop;
  logic                 do_push;
  logic                 retire;

  assign cnt_m2   = count - STK_CNT_W'(2);
  assign below    = op_stack[cnt_m2[STK_IDX_W-1:0]];
  assign has      = count != '0;
  assign more     = count > STK_CNT_W'(1);
  assign p_in     = prec_of(q_cmd.ch);
  assign out_free = !out_chan.valid || out_chan.ready;
  assign step     = q_valid && out_free;
  assign q_pop    = step && retire;

  always_comb begin
    emit    = 1'b0;
    e_char  = top;
    e_done  = 1'b0;
    e_last  = 1'b0;
    do_pop  = 1'b0;
    do_push = 1'b0;
    retire  = 1'b0;
    case (q_cmd.kind)
      KIND_ALNUM: begin
        emit   = 1'b1;
        e_char = q_cmd.ch;
        e_last = 1'b1;
        retire = 1'b1;
      end
      KIND_LPAREN: begin
        do_push = 1'b1;
        retire  = 1'b1;
      end
      KIND_RPAREN: begin
        if (!has) begin
          retire = 1'b1;
        end else if (top == CH_LPAREN) begin
          do_pop = 1'b1;
          retire = 1'b1;
        end else begin
          emit   = 1'b1;
          do_pop = 1'b1;
          e_last = !more || (below == CH_LPAREN);
          retire = !more;
        end
      end
      KIND_OP: begin
        if (has && (prec_of(top) >= p_in)) begin
          emit   = 1'b1;
          do_pop = 1'b1;
          e_last = !(more && (prec_of(below) >= p_in));
        end else begin
          do_push = 1'b1;
          retire  = 1'b1;
        end
      end
      KIND_END: begin
        emit = 1'b1;
        if (has) begin
          do_pop = 1'b1;
        end else begin
          e_char = CH_NUL;
          e_done = 1'b1;
          e_last = 1'b1;
          retire = 1'b1;
        end
      end
      default: begin
        retire = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step && do_push && (count != STK_CNT_W'(STACK_DEPTH))) begin
      op_stack[count[STK_IDX_W-1:0]] <= q_cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (step && do_pop) begin
      top <= below;
    end else if (step && do_push && (count != STK_CNT_W'(STACK_DEPTH))) begin
      top <= q_cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step && do_pop) begin
      count <= count - 1'b1;
    end else if (step && do_push && (count != STK_CNT_W'(STACK_DEPTH))) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (out_free) begin
      out_chan.valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_chan.char_out  <= e_char;
      out_chan.expr_done <= e_done;
      out_chan.run_last  <= e_last;
    end
  end
endmodule

>>> hw/rtl/infix_to_postfix_converter_unit.sv
// A beat that causes a result passes through the command queue and the output register.
// Throughput: the back retires one step a cycle unless the output stalls: a letter, digit
// or '(' is one step, each popped operator one, a ')' that meets '(' and an operator push
// one more, an end beat one per stack entry plus one. A four-entry queue sets the slack.
// Reset (rst, synchronous, active high) empties the stack, the queue and the output.
module infix_to_postfix_converter_unit (
  input  logic      clk,
  input  logic      rst,
  itp_in_if.sink    in_chan,
  itp_out_if.source out_chan
);
  import itp_pkg::*;

  // The front classifies each input beat combinationally and drops the
  // characters that have no effect; everything else becomes a command in
  // the queue. Input beats are taken whenever the queue has room, so the
  // front never waits on the output side directly.
  logic q_wr_valid;
  logic q_wr_ready;
  cmd_t q_wr_cmd;

  // The back pops commands once it has finished with them. A command that
  // pops several operators stays at the head of the queue while it pops
  // them, producing one result beat per operator popped.
  logic q_rd_valid;
  logic q_rd_pop;
  cmd_t q_rd_cmd;

  itp_front u_front (
    .in_chan (in_chan),
    .q_ready (q_wr_ready),
    .q_valid (q_wr_valid),
    .q_cmd   (q_wr_cmd)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_cmd   (q_wr_cmd),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_cmd   (q_rd_cmd),
    .rd_pop   (q_rd_pop)
  );

  // The back owns the operator stack and the output register. It only
  // advances when the output register is free or being emptied, so a
  // stalled sink simply holds the stack where it is.
  itp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_rd_valid),
    .q_cmd    (q_rd_cmd),
    .q_pop    (q_rd_pop),
    .out_chan (out_chan)
  );
endmodule
